// File: rtl/quaternion_rotation_unit_top_macros.svh
// Assertion macros shared by the quaternion rotation unit.
`ifndef QUATERNION_ROTATION_UNIT_TOP_MACROS_SVH
`define QUATERNION_ROTATION_UNIT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/qru_pkg.sv
// Types, codes and helper functions of the quaternion rotation unit.
package qru_pkg;

    localparam int W_WORD = 32;

    localparam logic [1:0] FN_LOAD = 2'd0;
    localparam logic [1:0] FN_FROM = 2'd1;
    localparam logic [1:0] FN_TO   = 2'd2;
    localparam logic [1:0] FN_LERP = 2'd3;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [W_WORD-1:0] word0;
        logic signed [W_WORD-1:0] word1;
        logic signed [W_WORD-1:0] word2;
        logic signed [W_WORD-1:0] word3;
        logic signed [W_WORD-1:0] word4;
        logic signed [W_WORD-1:0] word5;
        logic signed [W_WORD-1:0] word6;
        logic signed [W_WORD-1:0] word7;
        logic signed [W_WORD-1:0] word8;
        logic signed [W_WORD-1:0] progress;
    } t_in_item;

    typedef struct packed {
        logic signed [W_WORD-1:0] res0;
        logic signed [W_WORD-1:0] res1;
        logic signed [W_WORD-1:0] res2;
        logic signed [W_WORD-1:0] res3;
        logic signed [W_WORD-1:0] res4;
        logic signed [W_WORD-1:0] res5;
        logic signed [W_WORD-1:0] res6;
        logic signed [W_WORD-1:0] res7;
        logic signed [W_WORD-1:0] res8;
        logic                     bad;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MATSET,
        S_MUL,
        S_NORM,
        S_SQRT,
        S_DIVGO,
        S_DIV,
        S_FIN,
        S_MATOUT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MO_SQ,
        MO_MAT,
        MO_DOT,
        MO_BLEND
    } t_mulop;

    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic [33:0]        den;
    } t_div_req;

    typedef struct packed {
        logic        start;
        logic [63:0] val;
    } t_sqrt_req;

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Component pairs of the nine products used to build the matrix:
    // xy, xz, xw, yz, yw, zw, xx, yy, zz (w = 0, x = 1, y = 2, z = 3).
    function automatic logic [1:0] f_mat_a(input logic [3:0] k);
        case (k)
            4'd0, 4'd1, 4'd2, 4'd6: return 2'd1;
            4'd3, 4'd4, 4'd7:       return 2'd2;
            4'd5, 4'd8:             return 2'd3;
            default:                return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] f_mat_b(input logic [3:0] k);
        case (k)
            4'd0, 4'd7:             return 2'd2;
            4'd1, 4'd3, 4'd8:       return 2'd3;
            4'd6:                   return 2'd1;
            default:                return 2'd0;
        endcase
    endfunction

endpackage

// File: rtl/qru_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface qru_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/qru_mul.sv
// Shared signed 33 x 33 multiplier with a registered product.
module qru_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [63:0] o_p
);
    logic signed [63:0] r_p;

    // Operands never exceed 2^31 in magnitude, so 64 bits hold the product.
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a * i_b);
    end

    assign o_p = r_p;
endmodule

// File: rtl/qru_div.sv
// Restoring divider, one quotient bit per cycle, rounds half away from zero.
module qru_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qru_pkg::t_div_req  i_req,
    output logic               o_done,
    output logic signed [31:0] o_quo
);
    import qru_pkg::*;

    logic [6:0]  r_cnt;
    logic        r_done;
    logic        r_neg;
    logic [63:0] r_mag;
    logic [33:0] r_rem;
    logic [33:0] r_den;
    logic [34:0] rem_sh;
    logic        ge;
    logic [63:0] num_mag;

    assign num_mag = i_req.num[63] ? 64'(-i_req.num) : 64'(i_req.num);
    assign rem_sh  = {r_rem, r_mag[63]};
    assign ge      = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 7'd1);
            if (i_req.start) begin
                r_cnt <= 7'd64;
            end else if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    // The dividend register turns into the quotient as bits shift through.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.num[63];
            r_mag <= num_mag + 64'(i_req.den >> 1);
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_cnt != 7'd0) begin
            r_mag <= {r_mag[62:0], ge};
            r_rem <= ge ? 34'(rem_sh - {1'b0, r_den}) : rem_sh[33:0];
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quo = (r_mag > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-r_mag);
        end else begin
            o_quo = (r_mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : r_mag[31:0];
        end
    end

    assign o_done = r_done;
endmodule

// File: rtl/qru_sqrt.sv
// Digit-by-digit integer square root, rounded to nearest, one digit per cycle.
module qru_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qru_pkg::t_sqrt_req i_req,
    output logic              o_done,
    output logic [32:0]       o_root
);
    import qru_pkg::*;

    logic [5:0]  r_cnt;
    logic        r_done;
    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] trial;
    logic        ge;

    assign trial = r_res + r_bit;
    assign ge    = r_rem >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (i_req.start) begin
                r_cnt <= 6'd32;
            end else if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.val;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_cnt != 6'd0) begin
            r_rem <= ge ? r_rem - trial : r_rem;
            r_res <= ge ? (r_res >> 1) + r_bit : r_res >> 1;
            r_bit <= r_bit >> 2;
        end
    end

    // The remainder left over is the input minus the truncated root squared.
    assign o_root = 33'(r_res) + 33'(r_rem > r_res);
    assign o_done = r_done;
endmodule

// File: rtl/quaternion_rotation_unit_top.sv
// Top level of the quaternion rotation unit: sequencer and data registers.
//
//  channel | dir | payload     | handshake
//  i_in    | in  | t_in_item   | valid/ready, word taken when both high
//  o_out   | out | t_out_item  | valid/ready, word taken when both high
//
// One word at a time: i_in.ready is high only while the unit is idle.
// Work per word: func 2 uses only the multiplier; func 1 runs the square root and the
// 64-step divider three times; func 0 and 3 run the divider four times, func 0 skipping
// the square root when the sum of squares overflows.
// The result word holds on o_out until taken; a new word is accepted only after.
// i_rst_n is synchronous; it restores the identity quaternion.
`include "quaternion_rotation_unit_top_macros.svh"

module quaternion_rotation_unit_top #(
    parameter int FRAC_BITS = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qru_stream_if.sink   i_in,
    qru_stream_if.source o_out
);
    import qru_pkg::*;

    localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [32:0] ONE33 = 33'(ONE64);
    localparam logic signed [31:0] ONE32 = 32'(ONE64);
    localparam logic [63:0]        HALF  = 64'd1 << (FRAC_BITS - 1);

    t_state             r_state, n_state;
    t_mulop             r_op;
    logic [3:0]         r_k;
    logic [1:0]         r_func;
    logic [1:0]         r_di;
    logic [1:0]         r_big;
    t_in_item           r_in;
    logic signed [31:0] r_q   [4];
    logic signed [32:0] r_v   [4];
    logic signed [63:0] r_t   [9];
    logic signed [31:0] r_res [9];
    logic signed [31:0] r_p;
    logic signed [63:0] r_dot;
    logic [64:0]        r_acc;
    logic [33:0]        r_m;
    logic               r_bad;

    logic signed [31:0] w_in [9];
    logic [3:0]         mul_n;
    logic [3:0]         k_iss;
    logic [3:0]         k_cap;
    logic signed [32:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    t_div_req           div_req;
    logic               div_done;
    logic signed [31:0] div_quo;
    t_sqrt_req          sqrt_req;
    logic               sqrt_done;
    logic [32:0]        sqrt_root;
    logic signed [35:0] mm [9];
    logic signed [35:0] trace, arg, n1, n2, n3;
    logic [1:0]         big;
    logic [1:0]         slot;
    logic signed [31:0] p_clamp;

    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] q;
        mag = x[63] ? 64'(-x) : 64'(x);
        q   = (mag + HALF) >> FRAC_BITS;
        return x[63] ? -$signed(q) : $signed(q);
    endfunction

    qru_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    qru_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    qru_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign w_in[0] = r_in.word0;
    assign w_in[1] = r_in.word1;
    assign w_in[2] = r_in.word2;
    assign w_in[3] = r_in.word3;
    assign w_in[4] = r_in.word4;
    assign w_in[5] = r_in.word5;
    assign w_in[6] = r_in.word6;
    assign w_in[7] = r_in.word7;
    assign w_in[8] = r_in.word8;

    // Branch selection for the matrix-to-quaternion conversion.
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            mm[i] = 36'(w_in[i]);
        end
        trace = mm[0] + mm[4] + mm[8];
        if (trace > 36'sd0) begin
            arg = trace + 36'(ONE64);
            big = 2'd0;
            n1  = mm[7] - mm[5];
            n2  = mm[2] - mm[6];
            n3  = mm[3] - mm[1];
        end else if (mm[0] > mm[4] && mm[0] > mm[8]) begin
            arg = 36'(ONE64) + mm[0] - mm[4] - mm[8];
            big = 2'd1;
            n1  = mm[7] - mm[5];
            n2  = mm[1] + mm[3];
            n3  = mm[2] + mm[6];
        end else if (mm[4] > mm[8]) begin
            arg = 36'(ONE64) + mm[4] - mm[0] - mm[8];
            big = 2'd2;
            n1  = mm[2] - mm[6];
            n2  = mm[1] + mm[3];
            n3  = mm[5] + mm[7];
        end else begin
            arg = 36'(ONE64) + mm[8] - mm[0] - mm[4];
            big = 2'd3;
            n1  = mm[3] - mm[1];
            n2  = mm[2] + mm[6];
            n3  = mm[5] + mm[7];
        end
    end

    always_comb begin
        if (i_in.payload.progress < 32'sd0) begin
            p_clamp = '0;
        end else if (i_in.payload.progress > ONE32) begin
            p_clamp = ONE32;
        end else begin
            p_clamp = i_in.payload.progress;
        end
    end

    always_comb begin
        case (r_op)
            MO_SQ:    mul_n = 4'd4;
            MO_MAT:   mul_n = 4'd9;
            MO_DOT:   mul_n = 4'd4;
            MO_BLEND: mul_n = 4'd8;
            default:  mul_n = 4'd4;
        endcase
    end

    assign k_iss = (r_k < mul_n) ? r_k : 4'd0;
    assign k_cap = r_k - 4'd1;

    // A quotient of the conversion skips the slot that the root itself fills.
    assign slot = (r_func == FN_FROM && r_di >= r_big) ? r_di + 2'd1 : r_di;

    // Multiplier operands: one product issued per cycle, captured in the next cycle.
    always_comb begin
        case (r_op)
            MO_SQ: begin
                mul_a = r_v[k_iss[1:0]];
                mul_b = r_v[k_iss[1:0]];
            end
            MO_MAT: begin
                mul_a = 33'(r_q[f_mat_a(k_iss)]);
                mul_b = 33'(r_q[f_mat_b(k_iss)]);
            end
            MO_DOT: begin
                mul_a = 33'(r_q[k_iss[1:0]]);
                mul_b = 33'(w_in[{2'b00, k_iss[1:0]}]);
            end
            MO_BLEND: begin
                if (!k_iss[0]) begin
                    mul_a = ONE33 - 33'(r_p);
                    mul_b = 33'(r_q[k_iss[2:1]]);
                end else begin
                    mul_a = 33'(r_p);
                    mul_b = r_dot[63] ? -33'(w_in[{2'b00, k_iss[2:1]}])
                                      : 33'(w_in[{2'b00, k_iss[2:1]}]);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.payload.func)
                        FN_FROM: n_state = S_MATSET;
                        default: n_state = S_MUL;
                    endcase
                end
            end
            S_MATSET: n_state = (arg <= 36'sd0) ? S_DONE : S_SQRT;
            S_MUL: begin
                if (r_k == mul_n) begin
                    case (r_op)
                        MO_SQ:   n_state = S_NORM;
                        MO_MAT:  n_state = S_MATOUT;
                        default: n_state = S_MUL;
                    endcase
                end
            end
            S_NORM: begin
                if (r_acc[64]) begin
                    n_state = S_DIVGO;
                end else if (r_acc == 65'd0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT:   n_state = sqrt_done ? S_DIVGO : S_SQRT;
            S_DIVGO:  n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    if (r_di == ((r_func == FN_FROM) ? 2'd2 : 2'd3)) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_DIVGO;
                    end
                end
            end
            S_FIN:    n_state = S_DONE;
            S_MATOUT: n_state = S_DONE;
            S_DONE:   n_state = o_out.ready ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready     = (r_state == S_IDLE);
        o_out.valid    = (r_state == S_DONE);
        sqrt_req.start = 1'b0;
        sqrt_req.val   = 64'(r_acc);
        div_req.start  = (r_state == S_DIVGO);
        div_req.num    = 64'(r_v[r_di]) <<< FRAC_BITS;
        div_req.den    = r_m;
        case (r_state)
            S_MATSET: begin
                sqrt_req.start = (arg > 36'sd0);
                sqrt_req.val   = 64'(arg) << FRAC_BITS;
            end
            S_NORM: begin
                sqrt_req.start = !r_acc[64] && (r_acc != 65'd0);
            end
            default: begin
                sqrt_req.start = 1'b0;
            end
        endcase
        o_out.payload.res0 = r_res[0];
        o_out.payload.res1 = r_res[1];
        o_out.payload.res2 = r_res[2];
        o_out.payload.res3 = r_res[3];
        o_out.payload.res4 = r_res[4];
        o_out.payload.res5 = r_res[5];
        o_out.payload.res6 = r_res[6];
        o_out.payload.res7 = r_res[7];
        o_out.payload.res8 = r_res[8];
        o_out.payload.bad  = r_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q[0]  <= ONE32;
            r_q[1]  <= '0;
            r_q[2]  <= '0;
            r_q[3]  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && r_func != FN_LERP) begin
                for (int i = 0; i < 4; i++) begin
                    r_q[i] <= r_res[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_in   <= i_in.payload;
                r_func <= i_in.payload.func;
                r_p    <= p_clamp;
                r_k    <= '0;
                r_acc  <= '0;
                r_dot  <= '0;
                r_bad  <= 1'b0;
                for (int i = 0; i < 9; i++) begin
                    r_res[i] <= '0;
                end
                r_v[0] <= 33'(i_in.payload.word0);
                r_v[1] <= 33'(i_in.payload.word1);
                r_v[2] <= 33'(i_in.payload.word2);
                r_v[3] <= 33'(i_in.payload.word3);
                case (i_in.payload.func)
                    FN_TO:   r_op <= MO_MAT;
                    FN_LERP: r_op <= MO_DOT;
                    default: r_op <= MO_SQ;
                endcase
            end
            S_MATSET: begin
                r_v[0] <= 33'(n1);
                r_v[1] <= 33'(n2);
                r_v[2] <= 33'(n3);
                r_big  <= big;
                r_bad  <= (arg <= 36'sd0);
            end
            S_MUL: begin
                if (r_k != 4'd0) begin
                    case (r_op)
                        MO_SQ:  r_acc <= r_acc + 65'(mul_p);
                        MO_MAT: r_t[k_cap] <= f_rnd(mul_p);
                        MO_DOT: r_dot <= r_dot + f_rnd(mul_p);
                        MO_BLEND: begin
                            if (!k_cap[0]) begin
                                r_t[0] <= mul_p;
                            end else begin
                                r_v[k_cap[2:1]] <= 33'(f_rnd(r_t[0] + mul_p));
                            end
                        end
                        default: r_acc <= r_acc;
                    endcase
                end
                if (r_k == mul_n) begin
                    r_k <= '0;
                    case (r_op)
                        MO_DOT:   r_op <= MO_BLEND;
                        MO_BLEND: r_op <= MO_SQ;
                        default:  r_op <= r_op;
                    endcase
                end else begin
                    r_k <= r_k + 4'd1;
                end
            end
            S_NORM: begin
                r_di  <= '0;
                r_m   <= 34'h1_0000_0000;
                r_bad <= !r_acc[64] && (r_acc == 65'd0);
            end
            S_SQRT: begin
                r_di <= '0;
                if (sqrt_done) begin
                    if (r_func == FN_FROM) begin
                        r_m <= {sqrt_root, 1'b0};
                        r_res[{2'b00, r_big}] <= f_sat32(64'((sqrt_root + 33'd1) >> 1));
                    end else begin
                        r_m <= 34'(sqrt_root);
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_res[{2'b00, slot}] <= div_quo;
                    r_di                 <= r_di + 2'd1;
                end
            end
            S_MATOUT: begin
                r_res[0] <= f_sat32(ONE64 - 2 * (r_t[7] + r_t[8]));
                r_res[1] <= f_sat32(2 * (r_t[0] - r_t[5]));
                r_res[2] <= f_sat32(2 * (r_t[1] + r_t[4]));
                r_res[3] <= f_sat32(2 * (r_t[0] + r_t[5]));
                r_res[4] <= f_sat32(ONE64 - 2 * (r_t[6] + r_t[8]));
                r_res[5] <= f_sat32(2 * (r_t[3] - r_t[2]));
                r_res[6] <= f_sat32(2 * (r_t[1] - r_t[4]));
                r_res[7] <= f_sat32(2 * (r_t[3] + r_t[2]));
                r_res[8] <= f_sat32(ONE64 - 2 * (r_t[6] + r_t[7]));
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    `QRU_ASSERT_NOW(a_one_word_at_a_time, o_out.valid, !i_in.ready, "accepting while a result waits")
    `QRU_ASSERT_NOW(a_bad_clears_results, o_out.valid && o_out.payload.bad, (o_out.payload.res0 == 32'sd0) && (o_out.payload.res3 == 32'sd0) && (o_out.payload.res8 == 32'sd0), "bad result carries nonzero data")
    `QRU_ASSERT_NEXT(a_accept_leaves_idle, i_in.valid && i_in.ready, r_state != S_IDLE, "accepted word did not start work")
    `QRU_ASSERT_NOW(a_div_done_in_wait, div_done, r_state == S_DIV, "divider finished outside its wait state")

endmodule
